>>> sv/gnp_pkg.sv
// Shared types, constants and codes for the greedy number partitioner.
package gnp_pkg;

  // Fixed field widths of the stream and configuration ports
  localparam int IN_VALUE_W  = 32;
  localparam int OUT_INDEX_W = 4;
  localparam int OUT_SUM_W   = 40;
  localparam int OUT_TDATA_W = 88;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int BIN_COUNT_W = 5;

  // Defaults for the top-level parameters
  localparam int MAX_BINS_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int SUM_WIDTH_DEF   = 40;

  // Configuration register indexes and reset values
  localparam logic [CFG_INDEX_W-1:0] REG_BIN_COUNT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE      = 8'd1;
  localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RST = 5'd2;
  localparam logic                   MODE_LEAST    = 1'b0;
  localparam logic                   MODE_SNAKE    = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_LOAD,
    ST_ADD,
    ST_SPREAD,
    ST_DIFF,
    ST_DONE
  } state_t;

  // Shared arithmetic unit operations
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // One result item as handed from the sequencer to the output register
  typedef struct packed {
    logic [OUT_INDEX_W-1:0] bin_index;
    logic [OUT_SUM_W-1:0]   bin_total;
    logic [OUT_SUM_W-1:0]   spread;
    logic                   last_out;
    logic                   overflow;
  } res_t;

endpackage

>>> sv/gnp_alu.sv
// Shared arithmetic unit: saturating add, or subtract with borrow for compares.
module gnp_alu import gnp_pkg::*; #(
  parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
  input  alu_op_t              op,
  input  logic [SUM_WIDTH-1:0] a,
  input  logic [SUM_WIDTH-1:0] b,
  output logic [SUM_WIDTH-1:0] res,
  output logic                 flag
);

  logic [SUM_WIDTH:0] wide;

  // add: flag is saturation; sub: flag is borrow (a < b)
  always_comb begin
    case (op)
      ALU_ADD: begin
        wide = {1'b0, a} + {1'b0, b};
        flag = wide[SUM_WIDTH];
        res  = wide[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : wide[SUM_WIDTH-1:0];
      end
      ALU_SUB: begin
        wide = {1'b0, a} - {1'b0, b};
        flag = wide[SUM_WIDTH];
        res  = wide[SUM_WIDTH-1:0];
      end
      default: begin
        wide = '0;
        flag = 1'b0;
        res  = '0;
      end
    endcase
  end

endmodule

>>> sv/gnp_bin_mem.sv
// Bin sum memory: one write and one registered read port, per-entry valid bits.
module gnp_bin_mem import gnp_pkg::*; #(
  parameter int MAX_BINS  = MAX_BINS_DEF,
  parameter int SUM_WIDTH = SUM_WIDTH_DEF,
  localparam int KW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clr,
  input  logic                 wr_en,
  input  logic [KW-1:0]        wr_addr,
  input  logic [SUM_WIDTH-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [KW-1:0]        rd_addr,
  output logic [SUM_WIDTH-1:0] rd_data
);

  logic [SUM_WIDTH-1:0] mem [MAX_BINS];
  logic [MAX_BINS-1:0]  vld;

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // valid bits: an entry that is not valid reads as zero
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
  end

endmodule

>>> sv/gnp_seq.sv
// Sequencer: bin choice scan, bin update, spread scan and snake order.
module gnp_seq import gnp_pkg::*; #(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int SUM_WIDTH   = SUM_WIDTH_DEF,
  localparam int KW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic [BIN_COUNT_W-1:0] bin_count,
  input  logic                   mode,
  // input item
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [IN_VALUE_W-1:0]  in_value,
  input  logic                   in_last,
  // result item
  output logic                   res_valid,
  input  logic                   res_ready,
  output res_t                   res,
  // bin memory
  output logic                   mem_clr,
  output logic                   mem_we,
  output logic [KW-1:0]          mem_waddr,
  output logic [SUM_WIDTH-1:0]   mem_wdata,
  output logic                   mem_re,
  output logic [KW-1:0]          mem_raddr,
  input  logic [SUM_WIDTH-1:0]   mem_rdata,
  // shared arithmetic unit
  output alu_op_t                alu_op,
  output logic [SUM_WIDTH-1:0]   alu_a,
  output logic [SUM_WIDTH-1:0]   alu_b,
  input  logic [SUM_WIDTH-1:0]   alu_res,
  input  logic                   alu_flag
);

  localparam int NW = $clog2(MAX_BINS + 1);
  localparam int VW = (VALUE_WIDTH < IN_VALUE_W) ? VALUE_WIDTH : IN_VALUE_W;
  localparam int EW = (VW > SUM_WIDTH) ? VW : SUM_WIDTH;

  state_t               state, state_next;
  logic [NW-1:0]        cnt, cnt_next;
  logic                 pend, pend_next;
  logic [KW-1:0]        pend_idx, pend_idx_next;
  logic                 ph, ph_next;
  logic [KW-1:0]        k, k_next;
  logic [SUM_WIDTH-1:0] best, best_next;
  logic [SUM_WIDTH-1:0] sum, sum_next;
  logic                 ovf, ovf_next;
  logic [SUM_WIDTH-1:0] hi, hi_next;
  logic [SUM_WIDTH-1:0] lo, lo_next;
  logic [SUM_WIDTH-1:0] spread_r, spread_r_next;
  logic [VW-1:0]        v_q, v_q_next;
  logic                 last_q, last_q_next;
  logic [KW-1:0]        snake_pos, snake_pos_next;
  logic                 snake_back, snake_back_next;

  logic [NW-1:0] bins_used;
  logic [NW-1:0] last_bin;
  logic          pend_end;
  logic          read_more;
  logic [EW-1:0] v_ext;
  logic          v_big;
  logic [KW-1:0] snake_cur;

  // bins in use: zero counts as one, clipped to capacity
  always_comb begin
    if (bin_count == '0) begin
      bins_used = NW'(1);
    end else if (32'(bin_count) > MAX_BINS) begin
      bins_used = NW'(MAX_BINS);
    end else begin
      bins_used = NW'(bin_count);
    end
  end

  assign last_bin  = bins_used - NW'(1);
  assign pend_end  = pend && (NW'(pend_idx) == last_bin);
  assign read_more = (cnt < bins_used);

  // value wider than a sum saturates the bin outright
  assign v_ext = EW'(v_q);
  assign v_big = |(v_ext >> SUM_WIDTH);

  // snake position pulled back into the bins in use
  assign snake_cur = (NW'(snake_pos) >= bins_used) ? last_bin[KW-1:0] : snake_pos;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (mode == MODE_SNAKE) ? ST_READ : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pend_end) begin
          state_next = ST_ADD;
        end
      end
      ST_READ: state_next = ST_LOAD;
      ST_LOAD: state_next = ST_ADD;
      ST_ADD:  state_next = last_q ? ST_SPREAD : ST_DONE;
      ST_SPREAD: begin
        if (ph && pend_end) begin
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: state_next = ST_DONE;
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs: handshakes, memory ports, arithmetic unit operands
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    mem_clr   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = cnt[KW-1:0];
    alu_op    = ALU_SUB;
    alu_a     = best;
    alu_b     = mem_rdata;
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_SCAN: mem_re = read_more;
      ST_READ: begin
        mem_re    = 1'b1;
        mem_raddr = k;
      end
      ST_ADD: begin
        mem_we = 1'b1;
        alu_op = ALU_ADD;
        alu_b  = v_ext[SUM_WIDTH-1:0];
      end
      ST_SPREAD: begin
        if (!ph) begin
          alu_a = hi;
          alu_b = mem_rdata;
        end else begin
          alu_a  = mem_rdata;
          alu_b  = lo;
          mem_re = !pend_end && read_more;
        end
      end
      ST_DIFF: begin
        mem_clr = 1'b1;
        alu_a   = hi;
        alu_b   = lo;
      end
      ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign mem_waddr = k;
  assign mem_wdata = v_big ? {SUM_WIDTH{1'b1}} : alu_res;

  // datapath register updates
  always_comb begin
    cnt_next        = cnt;
    pend_next       = pend;
    pend_idx_next   = pend_idx;
    ph_next         = ph;
    k_next          = k;
    best_next       = best;
    sum_next        = sum;
    ovf_next        = ovf;
    hi_next         = hi;
    lo_next         = lo;
    spread_r_next   = spread_r;
    v_q_next        = v_q;
    last_q_next     = last_q;
    snake_pos_next  = snake_pos;
    snake_back_next = snake_back;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          v_q_next      = in_value[VW-1:0];
          last_q_next   = in_last;
          cnt_next      = '0;
          pend_next     = 1'b0;
          spread_r_next = '0;
          if (mode == MODE_SNAKE) begin
            // visit order repeats the end bins
            k_next = snake_cur;
            if (!snake_back) begin
              if (NW'(snake_cur) + NW'(1) >= bins_used) begin
                snake_back_next = 1'b1;
                snake_pos_next  = snake_cur;
              end else begin
                snake_pos_next = snake_cur + KW'(1);
              end
            end else begin
              if (snake_cur == '0) begin
                snake_back_next = 1'b0;
                snake_pos_next  = snake_cur;
              end else begin
                snake_pos_next = snake_cur - KW'(1);
              end
            end
          end
        end
      end
      ST_SCAN: begin
        // smallest sum, the later index wins a tie
        if (pend && (pend_idx == '0 || !alu_flag)) begin
          best_next = mem_rdata;
          k_next    = pend_idx;
        end
        if (read_more) begin
          cnt_next      = cnt + NW'(1);
          pend_idx_next = cnt[KW-1:0];
        end
        pend_next = read_more;
      end
      ST_LOAD: best_next = mem_rdata;
      ST_ADD: begin
        sum_next  = mem_wdata;
        ovf_next  = alu_flag || v_big;
        cnt_next  = '0;
        pend_next = 1'b0;
        ph_next   = 1'b1;
      end
      ST_SPREAD: begin
        if (!ph) begin
          // largest sum
          if (pend_idx == '0) begin
            hi_next = mem_rdata;
            lo_next = mem_rdata;
          end else if (alu_flag) begin
            hi_next = mem_rdata;
          end
          ph_next = 1'b1;
        end else begin
          // smallest sum, then fetch the next bin
          if (pend && pend_idx != '0 && alu_flag) begin
            lo_next = mem_rdata;
          end
          if (!pend_end && read_more) begin
            cnt_next      = cnt + NW'(1);
            pend_idx_next = cnt[KW-1:0];
            pend_next     = 1'b1;
            ph_next       = 1'b0;
          end
        end
      end
      ST_DIFF: begin
        spread_r_next   = alu_res;
        snake_pos_next  = '0;
        snake_back_next = 1'b0;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend       <= 1'b0;
      snake_pos  <= '0;
      snake_back <= 1'b0;
    end else begin
      state      <= state_next;
      pend       <= pend_next;
      snake_pos  <= snake_pos_next;
      snake_back <= snake_back_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cnt      <= cnt_next;
    pend_idx <= pend_idx_next;
    ph       <= ph_next;
    k        <= k_next;
    best     <= best_next;
    sum      <= sum_next;
    ovf      <= ovf_next;
    hi       <= hi_next;
    lo       <= lo_next;
    spread_r <= spread_r_next;
    v_q      <= v_q_next;
    last_q   <= last_q_next;
  end

  // result item
  assign res.bin_index = OUT_INDEX_W'(k);
  assign res.bin_total = OUT_SUM_W'(sum);
  assign res.spread    = OUT_SUM_W'(spread_r);
  assign res.last_out  = last_q;
  assign res.overflow  = ovf;

  // the updated bin is always one in use
  assert property (@(posedge clk) disable iff (rst) mem_we |-> (NW'(k) < bins_used))
    else $error("bin write outside the bins in use");

  // clearing the bins ends a set and hands the result on
  assert property (@(posedge clk) disable iff (rst) mem_clr |=> (state == ST_DONE))
    else $error("bin clear not followed by result");

  // an item that is not last skips the spread scan
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADD && !last_q) |=> (state == ST_DONE))
    else $error("spread scan on an item that is not last");

  // spread is zero unless the set ends
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last_out) |-> (res.spread == '0))
    else $error("nonzero spread on an item that is not last");

endmodule

>>> sv/greedy_number_partitioner_top.sv
// Top level of the greedy number partitioner: ports, configuration, output register.
//
// Values arrive on the s_axis channel, value in tdata and the end-of-set
// mark in tlast; one result leaves on m_axis for every value: bin index,
// new bin sum and spread in tdata, overflow in tuser, the set end in tlast.
// The cfg channel writes bin_count (index 0) and mode (index 1); other
// indexes are ignored. Write it only while no value is in flight (between
// values, which may be in the middle of a set).
// Least-loaded mode scans the bin sums one per cycle through a single read
// port of the bin memory. A last value adds a spread scan over the bins in
// use (the max and min compares share one subtractor), after which all bins
// and the snake position are cleared at once.
// s_axis_tready is high only while no value is being worked on. While m_axis
// stalls with a result still held, the next result waits in the sequencer
// and s_axis_tready stays low.
// Reset (rst, synchronous) empties all bins, returns the snake to bin 0
// going forward, and sets bin_count to 2 and mode to least-loaded.
module greedy_number_partitioner_top import gnp_pkg::*; #(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int SUM_WIDTH   = SUM_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input values
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_VALUE_W-1:0]  s_axis_tdata,   // [31:0] value
  input  logic                   s_axis_tlast,
  // results
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [3:0] bin_index, [43:4] bin_total,
                                                 // [83:44] spread, [87:84] zero
  output logic                   m_axis_tlast,
  output logic [0:0]             m_axis_tuser    // [0] overflow
);

  localparam int KW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  logic [BIN_COUNT_W-1:0] bin_count;
  logic                   mode;

  logic                 res_valid;
  logic                 res_ready;
  res_t                 res;
  res_t                 out_q;

  logic                 mem_clr;
  logic                 mem_we;
  logic [KW-1:0]        mem_waddr;
  logic [SUM_WIDTH-1:0] mem_wdata;
  logic                 mem_re;
  logic [KW-1:0]        mem_raddr;
  logic [SUM_WIDTH-1:0] mem_rdata;

  alu_op_t              alu_op;
  logic [SUM_WIDTH-1:0] alu_a;
  logic [SUM_WIDTH-1:0] alu_b;
  logic [SUM_WIDTH-1:0] alu_res;
  logic                 alu_flag;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count <= BIN_COUNT_RST;
      mode      <= MODE_LEAST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BIN_COUNT: bin_count <= cfg_data[BIN_COUNT_W-1:0];
        REG_MODE:      mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  gnp_seq #(
    .MAX_BINS    (MAX_BINS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .bin_count (bin_count),
    .mode      (mode),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_value  (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_clr   (mem_clr),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .alu_op    (alu_op),
    .alu_a     (alu_a),
    .alu_b     (alu_b),
    .alu_res   (alu_res),
    .alu_flag  (alu_flag)
  );

  gnp_bin_mem #(
    .MAX_BINS  (MAX_BINS),
    .SUM_WIDTH (SUM_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .clr     (mem_clr),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  gnp_alu #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .flag (alu_flag)
  );

  // output register: takes a result when empty or being drained
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_INDEX_W - 2 * OUT_SUM_W){1'b0}},
                         out_q.spread, out_q.bin_total, out_q.bin_index};
  assign m_axis_tlast = out_q.last_out;
  assign m_axis_tuser = out_q.overflow;

endmodule
